// ===== hw/rtl/psdf_pkg.sv =====
// ----------------------------------------------------------------------------
// psdf_pkg
// Shared types and constants of the pcap stream deframer: phase and status
// codes, the result record and the push bundle into the result queue.
// ----------------------------------------------------------------------------
package psdf_pkg;

    localparam int unsigned FILE_HDR_LEN      = 24;
    localparam int unsigned REC_HDR_LEN       = 16;
    localparam int unsigned IDX_W             = 5;
    localparam int unsigned CAP_W             = 19;
    localparam int unsigned OUT_DEPTH_DEFAULT = 4;

    localparam logic [31:0]      MAGIC_MICRO   = 32'ha1b2c3d4;
    localparam logic [31:0]      MAGIC_NANO    = 32'ha1b23c4d;
    localparam logic [31:0]      LINK_MASK     = 32'h03FFFFFF;
    localparam logic [31:0]      LINK_ETHERNET = 32'h00000001;
    localparam logic [7:0]       VER_MAJOR_LO  = 8'd2;
    localparam logic [7:0]       VER_MINOR_LO  = 8'd4;
    localparam logic [CAP_W-1:0] MAX_CAP_RESET = 19'd65535;

    typedef enum logic [4:0] {
        PH_FILE = 5'b00001,
        PH_REC  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_DONE = 5'b01000,
        PH_ERR  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_MAGIC      = 4'd1,
        ST_VERSION    = 4'd2,
        ST_LINKTYPE   = 4'd3,
        ST_OVER_SNAP  = 4'd4,
        ST_OVER_LIMIT = 4'd5,
        ST_TRUNC_FILE = 4'd6,
        ST_TRUNC_REC  = 4'd7,
        ST_TRUNC_DATA = 4'd8,
        ST_CLEAN_END  = 4'd9
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        payload_byte;
        logic              last_in_packet;
        logic [31:0]       stamp_seconds;
        logic [31:0]       stamp_fraction;
        logic              nanosecond_stamps;
        logic [31:0]       wire_length;
        logic [CAP_W-1:0]  captured_length;
        status_t           status;
        logic [31:0]       packet_count;
        logic              last_of_item;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hw/rtl/pcap_stream_deframer_core.sv =====
// ----------------------------------------------------------------------------
// pcap_stream_deframer_core
// Little-endian pcap file deframer: file header checks, record framing,
// payload pass-through and end-of-stream status.
// ----------------------------------------------------------------------------
// Takes at most one file byte per item and accepts an item every cycle while
// the result queue has room; each item is registered and parsed in one pass,
// and its results go into the result queue. An item that carries a payload
// byte or ends a good record header and also carries the end marker gives
// two results, which the single output stream hands on one at a time; other
// items give at most one. The result queue of OUT_DEPTH entries (at least
// three to keep one item per cycle) absorbs this and any output stall. No
// clearing pass follows reset. An error or the clean end is sticky: later
// items are taken and dropped until reset.
module pcap_stream_deframer_core
    import psdf_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tuser,   // byte_valid
    input  logic             s_tlast,   // end_of_stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // payload_byte, stamp_seconds, stamp_fraction, nanosecond_stamps,
    // wire_length, captured_length, status, packet_count
    output logic [159:0]     m_tdata,
    output logic [2:0]       m_tuser,   // kind, last_of_item
    output logic             m_tlast,   // last_in_packet
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data   // max_capture_length
);

    push_t   push;
    logic    room;
    result_t head;

    psdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push)
    );

    psdf_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {head.packet_count, head.status, head.captured_length,
                      head.wire_length, head.nanosecond_stamps, head.stamp_fraction,
                      head.stamp_seconds, head.payload_byte};
    assign m_tuser = {head.last_of_item, head.kind};
    assign m_tlast = head.last_in_packet;

endmodule

// ===== hw/rtl/psdf_parser.sv =====
// ----------------------------------------------------------------------------
// psdf_parser
// Input register, header store and framing state. Each registered item is
// parsed in one pass and yields up to two results for the result queue.
// ----------------------------------------------------------------------------
module psdf_parser
    import psdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             s_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             room,
    output push_t            push
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_bval_reg;
    logic             in_eos_reg;
    logic [7:0]       hs_reg [FILE_HDR_LEN];
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      snap_reg, snap_next;
    logic [CAP_W-1:0] rem_reg, rem_next;
    logic             nano_reg, nano_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [CAP_W-1:0] max_len_reg;
    logic             proceed;
    logic             hs_we;

    assign cfg_ready = 1'b1;
    assign proceed   = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || proceed;

    always_comb
    begin
        logic [31:0]      magic;
        logic [31:0]      link;
        logic [31:0]      cap;
        logic [CAP_W-1:0] rem_dec;
        logic             byte_v;
        logic             eos_v;
        status_t          st;
        phase_t           phase_mid;
        logic [IDX_W-1:0] idx_mid;
        result_t          byte_res;
        result_t          eos_res;

        magic     = {hs_reg[3], hs_reg[2], hs_reg[1], hs_reg[0]};
        link      = {in_byte_reg, hs_reg[22], hs_reg[21], hs_reg[20]};
        cap       = {hs_reg[11], hs_reg[10], hs_reg[9], hs_reg[8]};
        rem_dec   = (rem_reg != '0) ? rem_reg - CAP_W'(1) : rem_reg;
        byte_v    = 1'b0;
        eos_v     = 1'b0;
        st        = ST_OK;
        phase_mid = phase_reg;
        idx_mid   = idx_reg;
        snap_next = snap_reg;
        rem_next  = rem_reg;
        nano_next = nano_reg;
        cnt_next  = cnt_reg;
        hs_we     = 1'b0;
        byte_res  = '0;
        eos_res   = '0;

        if (in_bval_reg)
        begin
            case (phase_reg)
                PH_FILE:
                begin
                    hs_we = 1'b1;
                    if (idx_reg == IDX_W'(FILE_HDR_LEN - 1))
                    begin
                        idx_mid = '0;
                        if (magic == MAGIC_MICRO)
                            nano_next = 1'b0;
                        else if (magic == MAGIC_NANO)
                            nano_next = 1'b1;
                        else
                            st = ST_MAGIC;
                        if (st == ST_OK && (hs_reg[4] != VER_MAJOR_LO || hs_reg[5] != 8'd0
                            || hs_reg[6] != VER_MINOR_LO || hs_reg[7] != 8'd0))
                            st = ST_VERSION;
                        if (st == ST_OK && (link & LINK_MASK) != LINK_ETHERNET)
                            st = ST_LINKTYPE;
                        if (st != ST_OK)
                        begin
                            phase_mid      = PH_ERR;
                            byte_v         = 1'b1;
                            byte_res.kind  = KIND_STATUS;
                            byte_res.status = st;
                        end
                        else
                        begin
                            snap_next = {hs_reg[19], hs_reg[18], hs_reg[17], hs_reg[16]};
                            phase_mid = PH_REC;
                        end
                    end
                    else
                    begin
                        idx_mid = idx_reg + IDX_W'(1);
                    end
                end
                PH_REC:
                begin
                    hs_we = 1'b1;
                    if (idx_reg == IDX_W'(REC_HDR_LEN - 1))
                    begin
                        idx_mid = '0;
                        if (cap > snap_reg)
                            st = ST_OVER_SNAP;
                        else if (cap > {{(32 - CAP_W){1'b0}}, max_len_reg})
                            st = ST_OVER_LIMIT;
                        byte_v = 1'b1;
                        if (st != ST_OK)
                        begin
                            phase_mid       = PH_ERR;
                            byte_res.kind   = KIND_STATUS;
                            byte_res.status = st;
                        end
                        else
                        begin
                            byte_res.kind            = KIND_HEADER;
                            byte_res.stamp_seconds   = {hs_reg[3], hs_reg[2], hs_reg[1],
                                                        hs_reg[0]};
                            byte_res.stamp_fraction  = {hs_reg[7], hs_reg[6], hs_reg[5],
                                                        hs_reg[4]};
                            byte_res.wire_length     = {in_byte_reg, hs_reg[14], hs_reg[13],
                                                        hs_reg[12]};
                            byte_res.captured_length = cap[CAP_W-1:0];
                            if (cap == 32'd0)
                            begin
                                // empty record completes at its header
                                cnt_next                = cnt_reg + 32'd1;
                                byte_res.last_in_packet = 1'b1;
                            end
                            else
                            begin
                                rem_next  = cap[CAP_W-1:0];
                                phase_mid = PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        idx_mid = idx_reg + IDX_W'(1);
                    end
                end
                PH_DATA:
                begin
                    byte_v                = 1'b1;
                    byte_res.kind         = KIND_PAYLOAD;
                    byte_res.payload_byte = in_byte_reg;
                    rem_next              = rem_dec;
                    if (rem_dec == '0)
                    begin
                        byte_res.last_in_packet = 1'b1;
                        cnt_next                = cnt_reg + 32'd1;
                        phase_mid               = PH_REC;
                    end
                end
                default:
                begin
                end
            endcase
        end

        phase_next = phase_mid;
        idx_next   = idx_mid;
        if (in_eos_reg && (phase_mid inside {PH_FILE, PH_REC, PH_DATA}))
        begin
            eos_v        = 1'b1;
            eos_res.kind = KIND_STATUS;
            case (phase_mid)
                PH_FILE: eos_res.status = ST_TRUNC_FILE;
                PH_REC:  eos_res.status = (idx_mid != '0) ? ST_TRUNC_REC : ST_CLEAN_END;
                default: eos_res.status = ST_TRUNC_DATA;
            endcase
            phase_next = (eos_res.status == ST_CLEAN_END) ? PH_DONE : PH_ERR;
        end

        byte_res.nanosecond_stamps = nano_next;
        byte_res.packet_count      = cnt_next;
        byte_res.last_of_item      = !eos_v;
        eos_res.nanosecond_stamps  = nano_next;
        eos_res.packet_count       = cnt_next;
        eos_res.last_of_item       = 1'b1;

        push.count  = 2'd0;
        push.first  = byte_v ? byte_res : eos_res;
        push.second = eos_res;
        if (proceed)
            push.count = {1'b0, byte_v} + {1'b0, eos_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_FILE;
            idx_reg      <= '0;
            snap_reg     <= '0;
            rem_reg      <= '0;
            nano_reg     <= 1'b0;
            cnt_reg      <= '0;
            max_len_reg  <= MAX_CAP_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            if (proceed)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                snap_reg  <= snap_next;
                rem_reg   <= rem_next;
                nano_reg  <= nano_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_bval_reg <= s_tuser;
            in_eos_reg  <= s_tlast;
        end
        if (proceed && hs_we)
            hs_reg[idx_reg] <= in_byte_reg;
    end

    a_data_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_rec_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_REC |-> idx_reg < IDX_W'(REC_HDR_LEN))
        else $error("record header index out of range");

    a_final_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE || phase_reg == PH_ERR) |=> $stable(phase_reg))
        else $error("left a final phase without reset");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 32'd1))
        else $error("packet count moved by more than one");

endmodule

// ===== hw/rtl/psdf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// psdf_out_fifo
// Result queue: takes up to two results a cycle from the parser and hands
// one a cycle to the output stream while the stream is ready.
// ----------------------------------------------------------------------------
module psdf_out_fifo
    import psdf_pkg::*;
#(
    parameter int unsigned DEPTH = OUT_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_plus1;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign m_tvalid     = count_reg != '0;
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = m_tvalid && m_tready;
    // room for a full pair of results, pops in this cycle not counted
    assign room         = count_reg <= CW'(DEPTH - 2);
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |->
            ({1'b0, count_reg} + (CW + 1)'(push.count)) <= (CW + 1)'(DEPTH))
        else $error("push larger than free space");

    a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(rd_ptr_reg))
        else $error("head moved while stalled");

endmodule

// ===== tb/sv/pcap_stream_deframer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcap_stream_deframer_core_test
// Self-checking bench for the pcap stream deframer. Builds one capture file
// per run (good or broken file header, records with random stamps, lengths
// and payload, a random way to end the stream) and drives it byte by byte
// with random gaps on the input and random stalls on the output. A parse
// mirror in the bench predicts every result; results are checked in order.
// ----------------------------------------------------------------------------
module pcap_stream_deframer_core_test;
    import psdf_pkg::*;

    localparam logic [CAP_W-1:0] CAP_LIMIT_TOP = 19'd262144;

    class pcap_parse_mirror;
        result_t          pending_results[$];
        int unsigned      errors;
        logic [CAP_W-1:0] max_cap;
        phase_t           phase;
        int unsigned      hdr_idx;
        logic [7:0]       hdr_bytes[FILE_HDR_LEN];
        logic [31:0]      snap_limit;
        logic [CAP_W-1:0] remaining;
        logic             nano;
        logic [31:0]      record_total;

        function new();
            errors       = 0;
            max_cap      = MAX_CAP_RESET;
            phase        = PH_FILE;
            hdr_idx      = 0;
            snap_limit   = '0;
            remaining    = '0;
            nano         = 1'b0;
            record_total = '0;
            foreach (hdr_bytes[i])
                hdr_bytes[i] = 8'h00;
        endfunction

        function logic [31:0] word_at(int unsigned off);
            return {hdr_bytes[off + 3], hdr_bytes[off + 2], hdr_bytes[off + 1], hdr_bytes[off]};
        endfunction

        function void add_result(kind_t kind, logic [7:0] pay, logic last, logic [31:0] sec,
                                 logic [31:0] frac, logic [31:0] wire_len,
                                 logic [CAP_W-1:0] cap, status_t st);
            result_t r;
            r.kind              = kind;
            r.payload_byte      = pay;
            r.last_in_packet    = last;
            r.stamp_seconds     = sec;
            r.stamp_fraction    = frac;
            r.nanosecond_stamps = nano;
            r.wire_length       = wire_len;
            r.captured_length   = cap;
            r.status            = st;
            r.packet_count      = record_total;
            r.last_of_item      = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void parse_item(logic [7:0] data, logic has_byte, logic eos);
            int unsigned queued;
            status_t     st;
            logic [31:0] cap;
            result_t     tail;
            queued = pending_results.size();
            st     = ST_OK;
            if (has_byte)
            begin
                case (phase)
                    PH_FILE:
                    begin
                        hdr_bytes[hdr_idx] = data;
                        hdr_idx++;
                        if (hdr_idx == FILE_HDR_LEN)
                        begin
                            hdr_idx = 0;
                            if (word_at(0) == MAGIC_MICRO)
                                nano = 1'b0;
                            else if (word_at(0) == MAGIC_NANO)
                                nano = 1'b1;
                            else
                                st = ST_MAGIC;
                            if (st == ST_OK &&
                                word_at(4) != {8'h00, VER_MINOR_LO, 8'h00, VER_MAJOR_LO})
                                st = ST_VERSION;
                            if (st == ST_OK && (word_at(20) & LINK_MASK) != LINK_ETHERNET)
                                st = ST_LINKTYPE;
                            if (st != ST_OK)
                            begin
                                phase = PH_ERR;
                                add_result(KIND_STATUS, 8'h00, 1'b0, '0, '0, '0, '0, st);
                            end
                            else
                            begin
                                snap_limit = word_at(16);
                                phase      = PH_REC;
                            end
                        end
                    end
                    PH_REC:
                    begin
                        hdr_bytes[hdr_idx] = data;
                        hdr_idx++;
                        if (hdr_idx == REC_HDR_LEN)
                        begin
                            hdr_idx = 0;
                            cap     = word_at(8);
                            if (cap > snap_limit)
                                st = ST_OVER_SNAP;
                            else if (cap > 32'(max_cap))
                                st = ST_OVER_LIMIT;
                            if (st != ST_OK)
                            begin
                                phase = PH_ERR;
                                add_result(KIND_STATUS, 8'h00, 1'b0, '0, '0, '0, '0, st);
                            end
                            else if (cap == 0)
                            begin
                                // empty record completes at its header
                                record_total++;
                                add_result(KIND_HEADER, 8'h00, 1'b1, word_at(0), word_at(4),
                                           word_at(12), '0, ST_OK);
                            end
                            else
                            begin
                                remaining = cap[CAP_W-1:0];
                                phase     = PH_DATA;
                                add_result(KIND_HEADER, 8'h00, 1'b0, word_at(0), word_at(4),
                                           word_at(12), cap[CAP_W-1:0], ST_OK);
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (remaining != 0)
                            remaining--;
                        if (remaining == 0)
                        begin
                            record_total++;
                            phase = PH_REC;
                        end
                        add_result(KIND_PAYLOAD, data, remaining == 0, '0, '0, '0, '0, ST_OK);
                    end
                    default:
                        ;
                endcase
            end
            if (eos && (phase == PH_FILE || phase == PH_REC || phase == PH_DATA))
            begin
                if (phase == PH_FILE)
                    st = ST_TRUNC_FILE;
                else if (phase == PH_DATA)
                    st = ST_TRUNC_DATA;
                else if (hdr_idx != 0)
                    st = ST_TRUNC_REC;
                else
                    st = ST_CLEAN_END;
                phase = (st == ST_CLEAN_END) ? PH_DONE : PH_ERR;
                add_result(KIND_STATUS, 8'h00, 1'b0, '0, '0, '0, '0, st);
            end
            if (pending_results.size() > queued)
            begin
                tail              = pending_results.pop_back();
                tail.last_of_item = 1'b1;
                pending_results.push_back(tail);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d status %0d", got.kind, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("last_in_packet", 32'(want.last_in_packet),
                          32'(got.last_in_packet));
            compare_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
            compare_field("stamp_fraction", want.stamp_fraction, got.stamp_fraction);
            compare_field("nanosecond_stamps", 32'(want.nanosecond_stamps),
                          32'(got.nanosecond_stamps));
            compare_field("wire_length", want.wire_length, got.wire_length);
            compare_field("captured_length", 32'(want.captured_length),
                          32'(got.captured_length));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("packet_count", want.packet_count, got.packet_count);
            compare_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tuser;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [159:0]     m_tdata;
    logic [2:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    pcap_parse_mirror mirror = new();
    bit               steady;
    int unsigned      item_count;

    pcap_stream_deframer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Output side: check each accepted result, then pick the next ready.
    initial
    begin
        result_t     got;
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind              = kind_t'(m_tuser[1:0]);
                got.last_of_item      = m_tuser[2];
                got.last_in_packet    = m_tlast;
                got.payload_byte      = m_tdata[7:0];
                got.stamp_seconds     = m_tdata[39:8];
                got.stamp_fraction    = m_tdata[71:40];
                got.nanosecond_stamps = m_tdata[72];
                got.wire_length       = m_tdata[104:73];
                got.captured_length   = m_tdata[123:105];
                got.status            = status_t'(m_tdata[127:124]);
                got.packet_count      = m_tdata[159:128];
                mirror.check_result(got);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eos);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        mirror.parse_item(data, has_byte, eos);
        if (has_byte || eos)
            item_count++;
    endtask

    // Sprinkle empty items between file bytes.
    task automatic send_byte(input logic [7:0] data);
        if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
        send_item(data, 1'b1, 1'b0);
    endtask

    // Send a header and a body; cut < 0 sends it whole. Otherwise the end
    // marker follows the first cut bytes, on the last of them if eos_rides.
    task automatic send_frame(input logic [191:0] head, input int head_len, input int body_len,
                              input int cut, input bit eos_rides);
        logic [7:0] b;
        for (int i = 0; i < head_len + body_len; i++)
        begin
            if (cut == i && !eos_rides)
            begin
                send_item(8'($urandom), 1'b0, 1'b1);
                return;
            end
            b = (i < head_len) ? head[8*i +: 8] : 8'($urandom);
            if (cut == i + 1 && eos_rides)
            begin
                send_item(b, 1'b1, 1'b1);
                return;
            end
            send_byte(b);
        end
        if (cut == head_len + body_len && !eos_rides)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_record(input logic [31:0] sec, input logic [31:0] frac,
                               input logic [31:0] cap, input logic [31:0] wire_len,
                               input int body_len, input int cut, input bit eos_rides);
        send_frame({64'h0, wire_len, cap, frac, sec}, REC_HDR_LEN, body_len, cut, eos_rides);
    endtask

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] limit_for(int unsigned n);
        case (n % 4)
            1: return '0;
            2: return CAP_W'($urandom_range(1, 300));
            3: return CAP_W'($urandom_range(0, 262144));
            default: return CAP_LIMIT_TOP;
        endcase
    endfunction

    // Hold input until the block has drained, then write the limit.
    task automatic write_limit(input logic [CAP_W-1:0] value);
        s_tvalid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror.max_cap = value;
    endtask

    initial
    begin
        logic [31:0] magic;
        logic [31:0] version;
        logic [31:0] snap;
        logic [31:0] link;
        logic [31:0] cap;
        logic [31:0] usable;
        int unsigned header_mode;
        int unsigned next_switch;
        int unsigned phase_no;
        int unsigned waited;
        int          cut;
        bit          rides;

        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tuser    <= 1'b0;
        s_tlast    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        steady      = 1'b0;
        item_count  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_limit(CAP_LIMIT_TOP);

        magic   = $urandom_range(0, 1) ? MAGIC_NANO : MAGIC_MICRO;
        version = {8'h00, VER_MINOR_LO, 8'h00, VER_MAJOR_LO};
        // upper link type bits are masked off by the block
        link    = LINK_ETHERNET | (32'($urandom_range(0, 63)) << 26);
        case ($urandom_range(0, 3))
            0: snap = 32'hFFFF_FFFF;
            1: snap = 32'd65535;
            2: snap = $urandom_range(0, 300);
            default: snap = $urandom;
        endcase
        cut         = -1;
        rides       = 1'b0;
        header_mode = $urandom_range(0, 15);
        case (header_mode)
            0:
            begin
                magic = $urandom;
                if (magic == MAGIC_MICRO || magic == MAGIC_NANO)
                    magic ^= 32'h1;
                if ($urandom_range(0, 1))
                    version = $urandom;
            end
            1:
            begin
                version ^= 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    link = $urandom;
            end
            2:
            begin
                link = $urandom;
                if ((link & LINK_MASK) == LINK_ETHERNET)
                    link ^= 32'h2;
            end
            3:
            begin
                // cut inside the file header, down to an empty file
                cut   = $urandom_range(0, FILE_HDR_LEN - 1);
                rides = (cut != 0) && ($urandom_range(0, 1) == 1);
            end
            default:
                ;
        endcase
        send_frame({link, snap, 32'($urandom), 32'($urandom), version, magic},
                   FILE_HDR_LEN, 0, cut, rides);

        if (header_mode > 3)
        begin
            send_record(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, -1, 1'b0);
            send_item(8'hA5, 1'b0, 1'b0);
            if (snap != 0)
                send_record(32'hFFFF_FFFF, 32'h0000_0000, 32'h1, 32'h0000_0000, 1, -1, 1'b0);

            next_switch = item_count + 300;
            phase_no    = 0;
            while (item_count < 2000)
            begin
                if (item_count >= next_switch)
                begin
                    phase_no++;
                    write_limit(limit_for(phase_no));
                    steady      = ($urandom_range(0, 3) == 0);
                    next_switch = item_count + 300;
                end
                if (item_count >= 1700)
                    steady = 1'b1;
                usable = (snap < 32'(mirror.max_cap)) ? snap : 32'(mirror.max_cap);
                if (usable <= 300 && $urandom_range(0, 15) == 0)
                    cap = usable;
                else if ($urandom_range(0, 7) == 0)
                    cap = 0;
                else
                    cap = $urandom_range(0, (usable < 40) ? usable : 40);
                send_record(pick_stamp(), pick_stamp(), cap, pick_stamp(), cap, -1, 1'b0);
            end

            // end the file one way or another
            usable = (snap < 32'(mirror.max_cap)) ? snap : 32'(mirror.max_cap);
            rides  = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:
                    send_item(8'($urandom), 1'b0, 1'b1);
                1:
                begin
                    cap = $urandom_range(0, (usable < 20) ? usable : 20);
                    send_record(pick_stamp(), pick_stamp(), cap, pick_stamp(), cap,
                                REC_HDR_LEN + cap, 1'b1);
                end
                2:
                    send_record(pick_stamp(), pick_stamp(), 32'h0, pick_stamp(), 0,
                                $urandom_range(1, REC_HDR_LEN - 1), rides);
                3:
                begin
                    if (usable == 0)
                        send_record(pick_stamp(), pick_stamp(), 32'h0, pick_stamp(), 0,
                                    $urandom_range(1, REC_HDR_LEN - 1), rides);
                    else
                    begin
                        cap = $urandom_range(1, (usable < 20) ? usable : 20);
                        send_record(pick_stamp(), pick_stamp(), cap, pick_stamp(), cap,
                                    $urandom_range(REC_HDR_LEN, REC_HDR_LEN - 1 + cap), rides);
                    end
                end
                4:
                begin
                    if (snap < 32'hFFFF_0000)
                        cap = snap + 1 + $urandom_range(0, 7);
                    else
                        cap = 32'(mirror.max_cap) + 1;
                    send_record(pick_stamp(), pick_stamp(), cap, pick_stamp(), 0, -1, 1'b0);
                end
                default:
                begin
                    cap = 32'(mirror.max_cap) + 1 + $urandom_range(0, 3);
                    send_record(pick_stamp(), pick_stamp(), cap, pick_stamp(), 0, -1, 1'b0);
                end
            endcase
        end

        // the block is done or in error now: these must be dropped
        while (item_count < 2000)
        begin
            steady = (item_count >= 1700);
            send_item(8'($urandom), 1'($urandom), 1'($urandom));
        end
        steady = 1'b1;
        repeat (4) send_item(8'($urandom), 1'($urandom), 1'($urandom));
        s_tvalid <= 1'b0;

        waited = 0;
        while (mirror.pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (mirror.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", mirror.pending_results.size());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
